// ===== rtl/yrgb_pkg.sv =====
package yrgb_pkg;

    localparam int SAMPLE_W    = 6;
    localparam int LUMA4_W     = 4;
    localparam int CHAN_W      = 4;
    localparam int RGB_W       = 3 * CHAN_W;
    localparam int ADDR_W      = 20;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSPOSE_MODE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 11'd1024;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic [LUMA4_W-1:0]         luma4_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic signed [SAMPLE_W-1:0] offset_t;

    typedef struct packed {
        sample_t luma_top_left;
        sample_t luma_top_right;
        sample_t luma_bottom_left;
        sample_t luma_bottom_right;
        sample_t chroma_u;
        sample_t chroma_v;
    } block_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [RGB_W-1:0]  pixel_rgb;
        logic              last_of_block;
        logic              last_of_frame;
    } pixel_item_t;

    typedef struct packed {
        offset_t red;
        offset_t green;
        offset_t blue;
    } chroma_off_t;

    typedef enum logic [1:0] {
        PIX_TOP_LEFT,
        PIX_TOP_RIGHT,
        PIX_BOTTOM_LEFT,
        PIX_BOTTOM_RIGHT
    } pixel_sel_t;

endpackage

// ===== rtl/yrgb_block_if.sv =====
interface yrgb_block_if import yrgb_pkg::*; ();

    logic        valid;
    logic        ready;
    block_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/yrgb_pixel_if.sv =====
interface yrgb_pixel_if import yrgb_pkg::*; ();

    logic        valid;
    logic        ready;
    pixel_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/yrgb_cfg.sv =====
module yrgb_cfg import yrgb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_enable,
    input  cfg_index_t    cfg_index,
    input  cfg_data_t     cfg_data,
    output logic [WW-1:0] frame_w,
    output logic [HW-1:0] frame_h,
    output logic          transpose
);

    localparam int WX = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int HX = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

    cfg_data_t width_reg;
    cfg_data_t height_reg;
    logic      transpose_reg;

    logic [WX-1:0] w_ext;
    logic [WX-1:0] w_clamp;
    logic [HX-1:0] h_ext;
    logic [HX-1:0] h_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
            transpose_reg <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:    width_reg     <= cfg_data;
                REG_FRAME_HEIGHT:   height_reg    <= cfg_data;
                REG_TRANSPOSE_MODE: transpose_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        w_ext = WX'(width_reg);
        if (w_ext < WX'(2))
            w_clamp = WX'(2);
        else if (w_ext > WX'(MAX_WIDTH))
            w_clamp = WX'(MAX_WIDTH);
        else
            w_clamp = w_ext;

        h_ext = HX'(height_reg);
        if (h_ext < HX'(2))
            h_clamp = HX'(2);
        else if (h_ext > HX'(MAX_HEIGHT))
            h_clamp = HX'(MAX_HEIGHT);
        else
            h_clamp = h_ext;
    end

    assign frame_w   = {w_clamp[WW-1:1], 1'b0};
    assign frame_h   = {h_clamp[HW-1:1], 1'b0};
    assign transpose = transpose_reg;

endmodule

// ===== rtl/yrgb_position.sv =====
module yrgb_position import yrgb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int CW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
    localparam int RW = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [WW-1:0] frame_w,
    input  logic [HW-1:0] frame_h,
    input  logic          advance,
    output logic [CW-1:0] col,
    output logic [RW-1:0] row,
    output logic          frame_end
);

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic [WW-1:0] bw;
    logic [HW-1:0] bh;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic          last_col;
    logic          last_row;

    assign bw = WW'(frame_w[WW-1:1]);
    assign bh = HW'(frame_h[HW-1:1]);

    always_comb
    begin
        col_cur  = (WW'(col_reg) >= bw) ? '0 : col_reg;
        row_cur  = (HW'(row_reg) >= bh) ? '0 : row_reg;
        last_col = (WW'(col_cur) == bw - WW'(1));
        last_row = (HW'(row_cur) == bh - HW'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col       = col_cur;
    assign row       = row_cur;
    assign frame_end = last_col && last_row;

endmodule

// ===== rtl/yrgb_block_stage.sv =====
module yrgb_block_stage import yrgb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int CW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
    localparam int RW = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [WW-1:0] frame_w,
    input  logic [HW-1:0] frame_h,
    input  logic          transpose,
    input  logic [CW-1:0] col,
    input  logic [RW-1:0] row,
    input  logic          frame_end,
    output logic          advance,
    yrgb_block_if.sink    blocks,
    yrgb_pixel_if.source  pixels
);

    localparam int OW = (WW > HW) ? WW : HW;
    localparam int PW = (2 * OW + 1 > ADDR_W) ? 2 * OW + 1 : ADDR_W;

    logic        blk_valid_reg;
    logic        blk_valid_next;
    pixel_sel_t  sel_reg;
    pixel_sel_t  sel_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    luma4_t        luma_tl_reg;
    luma4_t        luma_tr_reg;
    luma4_t        luma_bl_reg;
    luma4_t        luma_br_reg;
    chroma_off_t   offs_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          frame_end_reg;
    pixel_item_t   out_item_reg;

    chroma_off_t   offs_in;
    logic signed [8:0] u_s;
    logic signed [8:0] v_s;
    logic signed [8:0] cb_sum;
    logic signed [8:0] cg_sum;
    logic signed [8:0] cr_sum;
    logic signed [8:0] cb_q;
    logic signed [8:0] cg_q;
    logic signed [8:0] cr_q;

    logic        load_out;
    logic        blk_done;
    luma4_t      luma_sel;
    logic        pix_r;
    logic        pix_c;
    logic [OW-1:0] col2;
    logic [OW-1:0] row2;
    logic [OW-1:0] mul_a;
    logic [OW-1:0] mul_b;
    logic [OW-1:0] add_c;
    logic [PW-1:0] addr_full;
    pixel_item_t pixel_next;

    function automatic logic [CHAN_W-1:0] clamp_chan(luma4_t y, offset_t off);
        logic signed [SAMPLE_W:0] s;
        s = $signed({3'b000, y}) + (SAMPLE_W + 1)'(off);
        if (s < 0)
            return '0;
        else if (s > $signed((SAMPLE_W + 1)'(15)))
            return CHAN_W'(15);
        else
            return s[CHAN_W-1:0];
    endfunction

    // chroma offsets, floor quarter by arithmetic shift
    always_comb
    begin
        u_s    = $signed({3'b000, blocks.data.chroma_u});
        v_s    = $signed({3'b000, blocks.data.chroma_v});
        cb_sum = (u_s <<< 1) + (u_s >>> 5) - 9'sd63;
        cg_sum = 9'sd33 - (u_s >>> 2) - (u_s >>> 3) - (v_s >>> 1) - (v_s >>> 4);
        cr_sum = v_s + (v_s >>> 3) - 9'sd35;
        cb_q   = cb_sum >>> 2;
        cg_q   = cg_sum >>> 2;
        cr_q   = cr_sum >>> 2;
        offs_in.blue  = cb_q[SAMPLE_W-1:0];
        offs_in.green = cg_q[SAMPLE_W-1:0];
        offs_in.red   = cr_q[SAMPLE_W-1:0];
    end

    assign load_out     = blk_valid_reg && (!out_valid_reg || pixels.ready);
    assign blk_done     = load_out && (sel_reg == PIX_BOTTOM_RIGHT);
    assign blocks.ready = !blk_valid_reg || blk_done;
    assign advance      = blocks.valid && blocks.ready;

    always_comb
    begin
        case (sel_reg)
            PIX_TOP_LEFT:    luma_sel = luma_tl_reg;
            PIX_TOP_RIGHT:   luma_sel = luma_tr_reg;
            PIX_BOTTOM_LEFT: luma_sel = luma_bl_reg;
            default:         luma_sel = luma_br_reg;
        endcase

        pix_r = sel_reg[1];
        pix_c = sel_reg[0];
        col2  = OW'({col_reg, pix_c});
        row2  = OW'({row_reg, pix_r});

        if (transpose)
        begin
            mul_a = col2;
            mul_b = OW'(frame_h);
            add_c = row2;
        end
        else
        begin
            mul_a = OW'(frame_h) - OW'(1) - row2;
            mul_b = OW'(frame_w);
            add_c = col2;
        end
        addr_full = PW'(mul_a) * PW'(mul_b) + PW'(add_c);

        pixel_next.pixel_address = addr_full[ADDR_W-1:0];
        pixel_next.pixel_rgb     = {clamp_chan(luma_sel, offs_reg.red),
                                    clamp_chan(luma_sel, offs_reg.green),
                                    clamp_chan(luma_sel, offs_reg.blue)};
        pixel_next.last_of_block = (sel_reg == PIX_BOTTOM_RIGHT);
        pixel_next.last_of_frame = (sel_reg == PIX_BOTTOM_RIGHT) && frame_end_reg;
    end

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        if (advance)
            blk_valid_next = 1'b1;
        else if (blk_done)
            blk_valid_next = 1'b0;

        sel_next = sel_reg;
        if (advance)
            sel_next = PIX_TOP_LEFT;
        else if (load_out)
        begin
            case (sel_reg)
                PIX_TOP_LEFT:    sel_next = PIX_TOP_RIGHT;
                PIX_TOP_RIGHT:   sel_next = PIX_BOTTOM_LEFT;
                PIX_BOTTOM_LEFT: sel_next = PIX_BOTTOM_RIGHT;
                default:         sel_next = PIX_TOP_LEFT;
            endcase
        end

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            sel_reg       <= PIX_TOP_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            luma_tl_reg   <= blocks.data.luma_top_left[SAMPLE_W-1:2];
            luma_tr_reg   <= blocks.data.luma_top_right[SAMPLE_W-1:2];
            luma_bl_reg   <= blocks.data.luma_bottom_left[SAMPLE_W-1:2];
            luma_br_reg   <= blocks.data.luma_bottom_right[SAMPLE_W-1:2];
            offs_reg      <= offs_in;
            col_reg       <= col;
            row_reg       <= row;
            frame_end_reg <= frame_end;
        end
        if (load_out)
            out_item_reg <= pixel_next;
    end

    assign pixels.valid = out_valid_reg;
    assign pixels.data  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_frame_flag_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.data.last_of_frame |-> pixels.data.last_of_block)
        else $error("last_of_frame without last_of_block");

    a_block_continues: assert property (@(posedge clk) disable iff (!rst_n)
        pixels.valid && pixels.ready && !pixels.data.last_of_block |=> pixels.valid)
        else $error("pixel stream of a block broke off");

    a_accept_starts_block: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> blk_valid_reg && (sel_reg == PIX_TOP_LEFT))
        else $error("accepted item did not start at the first pixel");

    a_pending_block_loads: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending block did not fill the output register");
`endif

endmodule

// ===== rtl/yuv420_to_rgb444_block_converter_core.sv =====
// Converts 2x2 blocks of 6-bit YUV 4:2:0 samples, taken in raster block order, into four
// 12-bit RGB pixels (R 11:8, G 7:4, B 3:0), each with its frame buffer address, emitted
// top-left, top-right, bottom-left, bottom-right. The result channel carries one pixel per
// cycle while the sink is ready; a block's first pixel passes the block registers, then
// the output register, and the next block is taken while its predecessor's last pixel moves
// into the output register. The address multiply is one registered pass through a single
// multiplier per pixel. Frame size and transpose mode are written through the configuration
// port by the user only while the block is idle; the block does not enforce this. Sizes are
// clamped to the supported range and forced even. There is no clearing pass after reset.
module yuv420_to_rgb444_block_converter_core import yrgb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_enable,
    input  cfg_index_t   cfg_index,
    input  cfg_data_t    cfg_data,
    yrgb_block_if.sink   blocks,
    yrgb_pixel_if.source pixels
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int RW = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1;

    logic [WW-1:0] frame_w;
    logic [HW-1:0] frame_h;
    logic          transpose;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          frame_end;
    logic          advance;

    yrgb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .frame_w          (frame_w),
        .frame_h          (frame_h),
        .transpose        (transpose)
    );

    yrgb_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .advance   (advance),
        .col       (col),
        .row       (row),
        .frame_end (frame_end)
    );

    yrgb_block_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_block_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_w   (frame_w),
        .frame_h   (frame_h),
        .transpose (transpose),
        .col       (col),
        .row       (row),
        .frame_end (frame_end),
        .advance   (advance),
        .blocks    (blocks),
        .pixels    (pixels)
    );

endmodule

// ===== tb/tb_yuv420_to_rgb444_block_converter_core.sv =====
`timescale 1ns / 100ps

module tb_yuv420_to_rgb444_block_converter_core;
    import yrgb_pkg::*;

    localparam int          MAX_W      = 1024;
    localparam int          MAX_H      = 1024;
    localparam int          IDLE_LIMIT = 3000;
    localparam cfg_index_t  REG_NONE   = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       cfg_write_enable;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    yrgb_block_if blocks_if ();
    yrgb_pixel_if pixels_if ();

    yuv420_to_rgb444_block_converter_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .blocks           (blocks_if),
        .pixels           (pixels_if)
    );

    // shadow registers and block position
    cfg_data_t   width_shadow;
    cfg_data_t   height_shadow;
    logic        transpose_shadow;
    int unsigned cur_col;
    int unsigned cur_row;

    pixel_item_t expected_pixels[$];

    int  blocks_sent;
    int  pixels_checked;
    int  frames_ended;
    int  configs_written;
    int  mismatch_count;
    int  idle_cycles;
    bit  tx_gappy;
    bit  rx_gappy;
    int  rx_hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned eff_size(cfg_data_t v, int unsigned maxv);
        int unsigned s;
        s = v;
        if (s < 2)
            s = 2;
        if (s > maxv)
            s = maxv;
        return s & 32'hFFFF_FFFE;
    endfunction

    function automatic logic [CHAN_W-1:0] sat4(int x);
        if (x < 0)
            return '0;
        if (x > 15)
            return 4'd15;
        return x[CHAN_W-1:0];
    endfunction

    function automatic sample_t luma_of(block_item_t b, pixel_sel_t sel);
        case (sel)
            PIX_TOP_LEFT:    return b.luma_top_left;
            PIX_TOP_RIGHT:   return b.luma_top_right;
            PIX_BOTTOM_LEFT: return b.luma_bottom_left;
            default:         return b.luma_bottom_right;
        endcase
    endfunction

    function automatic block_item_t mk_block(int tl, int tr, int bl, int br, int u, int v);
        block_item_t b;
        b.luma_top_left     = sample_t'(tl);
        b.luma_top_right    = sample_t'(tr);
        b.luma_bottom_left  = sample_t'(bl);
        b.luma_bottom_right = sample_t'(br);
        b.chroma_u          = sample_t'(u);
        b.chroma_v          = sample_t'(v);
        return b;
    endfunction

    function automatic block_item_t rand_block();
        return mk_block($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
    endfunction

    // convert one block into its four expected pixels and advance the position
    task automatic convert_block(input block_item_t b);
        int unsigned w, h, bw, bh, addr, r, c;
        int          u, v, off_r, off_g, off_b, lum;
        bit          frame_end;
        pixel_item_t px;
        w  = eff_size(width_shadow, MAX_W);
        h  = eff_size(height_shadow, MAX_H);
        bw = w >> 1;
        bh = h >> 1;
        if (cur_col >= bw)
            cur_col = 0;
        if (cur_row >= bh)
            cur_row = 0;
        u     = b.chroma_u;
        v     = b.chroma_v;
        off_b = ((u << 1) + (u >> 5) - 63) >>> 2;
        off_g = (-(u >> 2) - (u >> 3) - (v >> 1) - (v >> 4) + 33) >>> 2;
        off_r = (v + (v >> 3) - 35) >>> 2;
        frame_end = (cur_col == bw - 1) && (cur_row == bh - 1);
        for (int k = 0; k < 4; k++)
        begin
            r   = k >> 1;
            c   = k & 1;
            lum = luma_of(b, pixel_sel_t'(k)) >> 2;
            if (transpose_shadow)
                addr = (2 * cur_col + c) * h + 2 * cur_row + r;
            else
                addr = (h - 1 - 2 * cur_row - r) * w + 2 * cur_col + c;
            px.pixel_address = ADDR_W'(addr);
            px.pixel_rgb     = {sat4(lum + off_r), sat4(lum + off_g), sat4(lum + off_b)};
            px.last_of_block = (k == 3);
            px.last_of_frame = (k == 3) && frame_end;
            expected_pixels.push_back(px);
        end
        if (frame_end)
            frames_ended++;
        cur_col++;
        if (cur_col >= bw)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= bh)
                cur_row = 0;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    width_shadow = val;
            REG_FRAME_HEIGHT:   height_shadow = val;
            REG_TRANSPOSE_MODE: transpose_shadow = val[0];
            default: ;
        endcase
        configs_written++;
    endtask

    task automatic set_frame(input cfg_data_t w, input cfg_data_t h, input logic tr);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_TRANSPOSE_MODE, cfg_data_t'(tr));
    endtask

    task automatic send_block(input block_item_t b);
        int gap;
        gap = tx_gappy ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            blocks_if.valid <= 1'b0;
        end
        @(negedge clk);
        blocks_if.valid <= 1'b1;
        blocks_if.data  <= b;
        forever
        begin
            @(posedge clk);
            if (blocks_if.ready)
                break;
        end
        convert_block(b);
        blocks_sent++;
    endtask

    // drop valid and hold until every expected pixel has arrived
    task automatic wait_for_pixels();
        @(negedge clk);
        blocks_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_block(mk_block(0, 0, 0, 0, 0, 0));
        send_block(mk_block(63, 63, 63, 63, 63, 63));
        wait_for_pixels();
    endtask

    task automatic test_color_extremes();
        set_frame(11'd8, 11'd4, 1'b0);
        send_block(mk_block(0, 63, 0, 63, 63, 0));
        send_block(mk_block(63, 0, 63, 0, 0, 63));
        send_block(mk_block(0, 21, 42, 63, 32, 31));
        send_block(mk_block(63, 42, 21, 0, 31, 32));
        send_block(mk_block(1, 2, 4, 8, 16, 32));
        send_block(mk_block(62, 61, 59, 55, 47, 31));
        wait_for_pixels();
    endtask

    task automatic test_size_clamping();
        set_frame(11'd0, 11'd1, 1'b0);
        send_block(rand_block());
        send_block(rand_block());
        wait_for_pixels();
        set_frame(11'd2047, 11'd2047, 1'b1);
        send_block(rand_block());
        wait_for_pixels();
        set_frame(11'd1024, 11'd2, 1'b0);
        send_block(rand_block());
        wait_for_pixels();
        set_frame(11'd2, 11'd1024, 1'b1);
        send_block(rand_block());
        wait_for_pixels();
    endtask

    task automatic test_transposed_frame();
        set_frame(11'd7, 11'd5, 1'b1);
        repeat (7) send_block(rand_block());
        wait_for_pixels();
    endtask

    task automatic test_resize_mid_frame();
        set_frame(11'd8, 11'd8, 1'b0);
        write_reg(REG_NONE, 11'h555);
        repeat (10) send_block(rand_block());
        wait_for_pixels();
        set_frame(11'd4, 11'd4, 1'b0);
        write_reg(REG_NONE, 11'h2AA);
        repeat (4) send_block(rand_block());
        wait_for_pixels();
    endtask

    function automatic cfg_data_t rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return cfg_data_t'($urandom_range(2, 16));
        else if (r < 80)
            return cfg_data_t'($urandom_range(0, 2047));
        else if (r < 90)
            return ($urandom_range(0, 1) != 0) ? 11'd2 : 11'd1024;
        else
            return cfg_data_t'($urandom_range(0, 3));
    endfunction

    task automatic test_random_frames(input int target);
        int n, start;
        start = blocks_sent;
        while (blocks_sent - start < target)
        begin
            set_frame(rand_size(), rand_size(), 1'($urandom_range(0, 1)));
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_gappy = ($urandom_range(0, 3) != 0);
            n = $urandom_range(4, 24);
            repeat (n) send_block(rand_block());
            wait_for_pixels();
        end
        tx_gappy = 1'b1;
        rx_gappy = 1'b1;
    endtask

    task automatic test_output_hold_off();
        set_frame(11'd6, 11'd6, 1'b0);
        tx_gappy     = 1'b0;
        rx_hold_left = 200;
        repeat (16) send_block(rand_block());
        wait_for_pixels();
        tx_gappy = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_frame(11'd4, 11'd6, 1'b1);
        repeat (6) send_block(rand_block());
        wait_for_pixels();
        repeat (6) send_block(rand_block());
        wait_for_pixels();
    endtask

    // sink side: random stalls plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left      = 0;
        pixels_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                pixels_if.ready <= 1'b0;
                rx_hold_left--;
            end
            else
            begin
                if (stall_left == 0 && rx_gappy)
                    stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    pixels_if.ready <= 1'b0;
                    stall_left--;
                end
                else
                    pixels_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_item_t exp_px;
        if (rst_n && pixels_if.valid && pixels_if.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel item: address %0d rgb %03h",
                       pixels_if.data.pixel_address, pixels_if.data.pixel_rgb);
                mismatch_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                pixels_checked++;
                if (pixels_if.data.pixel_address !== exp_px.pixel_address)
                begin
                    $error("pixel_address: expected %0d, got %0d",
                           exp_px.pixel_address, pixels_if.data.pixel_address);
                    mismatch_count++;
                end
                if (pixels_if.data.pixel_rgb !== exp_px.pixel_rgb)
                begin
                    $error("pixel_rgb: expected %03h, got %03h",
                           exp_px.pixel_rgb, pixels_if.data.pixel_rgb);
                    mismatch_count++;
                end
                if (pixels_if.data.last_of_block !== exp_px.last_of_block)
                begin
                    $error("last_of_block: expected %0b, got %0b",
                           exp_px.last_of_block, pixels_if.data.last_of_block);
                    mismatch_count++;
                end
                if (pixels_if.data.last_of_frame !== exp_px.last_of_frame)
                begin
                    $error("last_of_frame: expected %0b, got %0b",
                           exp_px.last_of_frame, pixels_if.data.last_of_frame);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((blocks_if.valid && blocks_if.ready) || (pixels_if.valid && pixels_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d cycles without an item, %0d pixels pending",
                     idle_cycles, expected_pixels.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = REG_FRAME_WIDTH;
        cfg_data         = '0;
        blocks_if.valid  = 1'b0;
        blocks_if.data   = '0;
        width_shadow     = SIZE_RESET;
        height_shadow    = SIZE_RESET;
        transpose_shadow = 1'b0;
        cur_col          = 0;
        cur_row          = 0;
        blocks_sent      = 0;
        pixels_checked   = 0;
        frames_ended     = 0;
        configs_written  = 0;
        mismatch_count   = 0;
        idle_cycles      = 0;
        tx_gappy         = 1'b1;
        rx_gappy         = 1'b1;
        rx_hold_left     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_color_extremes();
        test_size_clamping();
        test_transposed_frame();
        test_resize_mid_frame();
        test_random_frames(110);
        test_output_hold_off();
        test_sender_pause();

        wait_for_pixels();
        repeat (10) @(posedge clk);

        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected pixels never arrived", expected_pixels.size());
            mismatch_count++;
        end
        $display("covered %0d blocks, %0d pixels checked, %0d frame ends, %0d register writes",
                 blocks_sent, pixels_checked, frames_ended, configs_written);
        $display("flipped and transposed layouts, clamped sizes, resizes mid-frame, stalls");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/yrgb_pkg.sv
rtl/yrgb_block_if.sv
rtl/yrgb_pixel_if.sv
rtl/yrgb_cfg.sv
rtl/yrgb_position.sv
rtl/yrgb_block_stage.sv
rtl/yuv420_to_rgb444_block_converter_core.sv
tb/tb_yuv420_to_rgb444_block_converter_core.sv
